// ===== hw/rtl/mbcd_pkg.sv =====
// Shared types and constants for the multibyte character decoder and classifier.
`timescale 1ns / 1ps
package mbcd_pkg;

	localparam int ByteW  = 8;
	localparam int CodeW  = 21;
	localparam int ClassW = 3;
	localparam int AddrW  = 3;
	localparam int DataW  = 32;

	// Register index of the encoding select, taken from the word address.
	localparam logic REG_ENCODING = 1'b0;

	typedef enum logic [1:0] {
		ENC_UTF8 = 2'd0,
		ENC_EUC  = 2'd1,
		ENC_SJIS = 2'd2,
		ENC_RSVD = 2'd3
	} enc_t;

	typedef enum logic [ClassW-1:0] {
		CLS_OTHER = 3'd0,
		CLS_DIGIT = 3'd1,
		CLS_ROMAN = 3'd2,
		CLS_HIRA  = 3'd3,
		CLS_KATA  = 3'd4,
		CLS_KANJI = 3'd5
	} class_t;

	// Character being gathered: partial code point or the two-byte lead byte.
	typedef struct packed {
		logic [CodeW-1:0] held;
		logic [1:0]       needed;
	} gather_t;

	// Outcome of one byte step.
	typedef struct packed {
		logic             emit;
		logic [CodeW-1:0] code;
		logic             malformed;
		logic             last;
	} dec_t;

endpackage

// ===== hw/rtl/mbcd_if.sv =====
// Byte request channel and character result channel interfaces.
`timescale 1ns / 1ps
interface mbcd_in_if import mbcd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [ByteW-1:0] in_byte;
	logic             end_of_text;

	modport source (output valid, in_byte, end_of_text, input ready);
	modport sink (input valid, in_byte, end_of_text, output ready);
endinterface

interface mbcd_out_if import mbcd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CodeW-1:0]  char_code;
	logic [ClassW-1:0] char_class;
	logic              malformed;
	logic              last;

	modport source (output valid, char_code, char_class, malformed, last, input ready);
	modport sink (input valid, char_code, char_class, malformed, last, output ready);
endinterface

// ===== hw/rtl/mbcd_decode.sv =====
// Byte step of the UTF-8, EUC and Shift-JIS character gatherer.
`timescale 1ns / 1ps
module mbcd_decode import mbcd_pkg::*; (
	input  enc_t             enc,
	input  logic [ByteW-1:0] in_byte,
	input  logic             eot,
	input  gather_t          cur,
	output gather_t          nxt,
	output dec_t             dec
);

	logic [CodeW-1:0] cont;
	logic             two_byte;

	assign two_byte = (enc == ENC_EUC) || (enc == ENC_SJIS);
	assign cont     = {cur.held[14:0], in_byte[5:0]};

	always_comb begin
		nxt = cur;
		dec = '0;
		if (two_byte) begin
			if (cur.needed == 2'd0) begin
				if (in_byte < 8'h80 ||
				    (enc == ENC_SJIS && in_byte inside {[8'hA0:8'hDF]})) begin
					dec.emit = 1'b1;
					dec.code = {13'd0, in_byte};
				end else if (eot) begin
					dec.emit      = 1'b1;
					dec.malformed = 1'b1;
				end else begin
					nxt.held   = {13'd0, in_byte};
					nxt.needed = 2'd1;
				end
			end else begin
				// Second byte is taken whatever its value.
				dec.emit = 1'b1;
				dec.code = {5'd0, cur.held[7:0], in_byte};
				nxt      = '0;
			end
		end else begin
			if (cur.needed == 2'd0) begin
				if (in_byte < 8'h80) begin
					dec.emit = 1'b1;
					dec.code = {13'd0, in_byte};
				end else if (in_byte >= 8'hF8 || eot) begin
					dec.emit      = 1'b1;
					dec.malformed = 1'b1;
				end else if (in_byte >= 8'hF0) begin
					nxt.held   = {18'd0, in_byte[2:0]};
					nxt.needed = 2'd3;
				end else if (in_byte >= 8'hE0) begin
					nxt.held   = {17'd0, in_byte[3:0]};
					nxt.needed = 2'd2;
				end else begin
					// Stray continuation bytes lead a two-byte sequence.
					nxt.held   = {16'd0, in_byte[4:0]};
					nxt.needed = 2'd1;
				end
			end else if (in_byte[7:6] != 2'b10) begin
				dec.emit      = 1'b1;
				dec.malformed = 1'b1;
				nxt           = '0;
			end else if (cur.needed == 2'd1) begin
				dec.emit = 1'b1;
				dec.code = cont;
				nxt      = '0;
			end else begin
				nxt.held   = cont;
				nxt.needed = cur.needed - 2'd1;
				if (eot) begin
					dec.emit      = 1'b1;
					dec.malformed = 1'b1;
				end
			end
		end
		dec.last = eot;
		if (dec.emit && eot) begin
			nxt = '0;
		end
	end

endmodule

// ===== hw/rtl/mbcd_classify.sv =====
// Character class lookup for code points and packed two-byte codes.
`timescale 1ns / 1ps
module mbcd_classify import mbcd_pkg::*; (
	input  enc_t             enc,
	input  logic [CodeW-1:0] code,
	output class_t           cls
);

	logic [ByteW-1:0] hi;
	logic [ByteW-1:0] lo;

	assign hi = code[15:8];
	assign lo = code[7:0];

	always_comb begin
		cls = CLS_OTHER;
		case (enc)
			ENC_EUC: begin
				if (lo inside {[8'h30:8'h39]} || (hi == 8'hA3 && lo inside {[8'hB0:8'hB9]}))
					cls = CLS_DIGIT;
				else if (lo inside {[8'h41:8'h5A], [8'h61:8'h7A]} ||
				         (hi == 8'hA3 && lo inside {[8'hC1:8'hDA], [8'hE1:8'hFA]}))
					cls = CLS_ROMAN;
				else if (hi == 8'hA4 && lo inside {[8'hA1:8'hF3]})
					cls = CLS_HIRA;
				else if ((hi == 8'hA5 && lo inside {[8'hA1:8'hF6]}) ||
				         (hi == 8'hA1 && lo == 8'hBC) || hi == 8'h8E)
					cls = CLS_KATA;
				else if (hi inside {[8'hB0:8'hF4]})
					cls = CLS_KANJI;
			end
			ENC_SJIS: begin
				if ((hi == 8'h00 && lo inside {[8'h30:8'h39]}) ||
				    (hi == 8'h82 && lo inside {[8'h4F:8'h58]}))
					cls = CLS_DIGIT;
				else if ((hi == 8'h00 && lo inside {[8'h41:8'h5A], [8'h61:8'h7A]}) ||
				         (hi == 8'h82 && lo inside {[8'h60:8'h79], [8'h81:8'h9A]}))
					cls = CLS_ROMAN;
				else if (hi == 8'h82 && lo inside {[8'h9F:8'hF1]})
					cls = CLS_HIRA;
				else if ((hi == 8'h83 && lo inside {[8'h40:8'h96]}) ||
				         (hi == 8'h81 && lo == 8'h5B) ||
				         (hi == 8'h00 && lo inside {[8'hA6:8'hDF]}))
					cls = CLS_KATA;
				else if (hi inside {[8'h88:8'h9F], [8'hE0:8'hEA]})
					cls = CLS_KANJI;
			end
			default: begin
				if (code inside {[21'h41:21'h5A], [21'h61:21'h7A],
				                 [21'hFF21:21'hFF3A], [21'hFF41:21'hFF5A]})
					cls = CLS_ROMAN;
				else if (code inside {[21'h3040:21'h3096]})
					cls = CLS_HIRA;
				else if ((code inside {[21'h30A0:21'h30FF]} && code != 21'h30FB) ||
				         code inside {[21'hFF66:21'hFF9F]})
					cls = CLS_KATA;
				else if (code inside {[21'h30:21'h39], [21'hFF10:21'hFF19]})
					cls = CLS_DIGIT;
				else if (code inside {[21'h3400:21'h4DBF], [21'h4E00:21'h9FFF],
				                      [21'hF900:21'hFAFF], [21'h20000:21'h2A6DF],
				                      [21'h2A700:21'h2B81F], [21'h2F800:21'h2FA1F]})
					cls = CLS_KANJI;
			end
		endcase
	end

endmodule

// ===== hw/rtl/multibyte_char_decode_classify.sv =====
// Top level of the multibyte character decoder and classifier.
// Usage:
//   in_ch carries one text byte per request with an end_of_text flag. out_ch
//   carries one result per completed character: code, class, a malformed flag
//   and last, which marks the result that ends the text. Bytes that only add
//   to a character in progress give no result.
//   The encoding register (byte address 0 of the APB port) selects UTF-8, EUC
//   or Shift-JIS. Writing it drops any partly gathered character; write it only
//   while no byte is in flight.
// Timing:
//   A byte accepted into the input register is decoded and classified
//   combinationally; its result is registered when the byte advances. One
//   byte is taken every cycle while out_ch is not stalled; the rate is set by
//   the input register feeding the combinational decode and class logic.
// Reset and stalls:
//   arst_n clears the encoding to UTF-8, the gathered character and both
//   valid flags. While out_ch is stalled the result register holds and one
//   more byte is parked in the input register; in_ch.ready then drops.
`timescale 1ns / 1ps
module multibyte_char_decode_classify import mbcd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	mbcd_in_if.sink          in_ch,
	mbcd_out_if.source       out_ch,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [DataW-1:0] pwdata,
	output logic [DataW-1:0] prdata,
	output logic             pready
);

	enc_t             enc_q;
	gather_t          gather_q;
	gather_t          gather_nxt;
	dec_t             dec;
	class_t           cls;
	logic             cfg_wr;

	logic             valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic             eot_s1;

	logic             valid_s2;
	logic [CodeW-1:0] code_s2;
	class_t           class_s2;
	logic             bad_s2;
	logic             last_s2;

	logic             advance;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ENCODING);
	assign prdata = (paddr[2] == REG_ENCODING) ? {{(DataW-2){1'b0}}, enc_q} : '0;

	assign advance     = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enc_q    <= ENC_UTF8;
			gather_q <= '0;
		end else if (cfg_wr) begin
			enc_q    <= enc_t'(pwdata[1:0]);
			gather_q <= '0;
		end else if (advance) begin
			gather_q <= gather_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.in_byte;
			eot_s1  <= in_ch.end_of_text;
		end
	end

	mbcd_decode u_decode (
		.enc     (enc_q),
		.in_byte (byte_s1),
		.eot     (eot_s1),
		.cur     (gather_q),
		.nxt     (gather_nxt),
		.dec     (dec)
	);

	mbcd_classify u_classify (
		.enc  (enc_q),
		.code (dec.code),
		.cls  (cls)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= dec.emit;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && dec.emit) begin
			code_s2  <= dec.code;
			class_s2 <= dec.malformed ? CLS_OTHER : cls;
			bad_s2   <= dec.malformed;
			last_s2  <= dec.last;
		end
	end

	assign out_ch.valid      = valid_s2;
	assign out_ch.char_code  = code_s2;
	assign out_ch.char_class = class_s2;
	assign out_ch.malformed  = bad_s2;
	assign out_ch.last       = last_s2;

	// A register write always leaves the gatherer idle.
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> gather_q.needed == 2'd0)
		else $error("gatherer not idle after encoding write");

	// The end of the text always gives a result and leaves the gatherer idle.
	a_eot_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && eot_s1 && !cfg_wr |=> valid_s2 && last_s2 && gather_q.needed == 2'd0)
		else $error("end of text did not close the character");

	// A held byte with a stalled result register blocks new requests.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !out_ch.ready |-> !in_ch.ready)
		else $error("request taken while both stages are full");

	// A malformed result always reports the empty code.
	a_bad_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && bad_s2 |-> code_s2 == '0 && class_s2 == CLS_OTHER)
		else $error("malformed result carries a code");

endmodule
